// File: rtl/i2cm_pkg.sv
// Shared types and codes for the I2C master register access block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package i2cm_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Sequencer phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_START     = 10'b00_0000_0010,
    PH_SEND      = 10'b00_0000_0100,
    PH_SEND_TAIL = 10'b00_0000_1000,
    PH_WACK      = 10'b00_0001_0000,
    PH_RECV_PRE  = 10'b00_0010_0000,
    PH_RECV_BIT  = 10'b00_0100_0000,
    PH_RECV_POST = 10'b00_1000_0000,
    PH_SACK      = 10'b01_0000_0000,
    PH_STOP      = 10'b10_0000_0000
  } phase_e;

  // Transaction stage: which byte of the frame is being handled
  typedef enum logic [1:0] {
    ST_ADDR_W = 2'd0,
    ST_REG    = 2'd1,
    ST_DATA   = 2'd2,
    ST_READ   = 2'd3
  } stage_e;

  // One input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  // One result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       nack_error;
    logic       busy_res;
  } result_t;

endpackage

// File: rtl/i2cm_in_stage.sv
// Input register for the I2C master: holds one request beat until the sequencer takes it.
// Depends on i2cm_pkg (item_t).
module i2cm_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2cm_pkg::item_t    in_item_i,
  input  logic               take_i,
  output logic               valid_o,
  output i2cm_pkg::item_t    item_o
);

  logic            valid_q;
  i2cm_pkg::item_t item_q;

  // Stall only when a held beat cannot move on this cycle
  assign in_stall_o = valid_q & ~take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/i2cm_seq.sv
// Pin-level I2C sequencer: state registers and the single-tick step logic.
// Depends on i2cm_pkg (phase_e, stage_e, item_t, result_t, request codes).
module i2cm_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  i2cm_pkg::item_t    item_i,
  output i2cm_pkg::result_t  res_o
);

  i2cm_pkg::phase_e phase_q, phase_d;
  i2cm_pkg::stage_e stage_q, stage_d;
  logic [2:0] step_q, step_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [6:0] addr_q, addr_d;
  logic [7:0] reg_q, reg_d;
  logic       rmode_q, rmode_d;
  logic       hold_q, hold_d;
  logic       abort_q, abort_d;

  i2cm_pkg::phase_e ph;
  i2cm_pkg::stage_e stg;
  logic [2:0] t;
  logic       begin_req;
  logic       send_bit;
  logic       sack_lvl;
  i2cm_pkg::result_t res;

  assign begin_req = (phase_q == i2cm_pkg::PH_IDLE) &&
                     ((item_i.req_type == i2cm_pkg::REQ_WRITE) ||
                      (item_i.req_type == i2cm_pkg::REQ_READ));
  assign send_bit  = shift_q[~bit_q];
  assign sack_lvl  = (left_q == 8'd0);

  // One tick of the sequencer
  always_comb begin
    addr_d  = addr_q;
    reg_d   = reg_q;
    left_d  = left_q;
    rmode_d = rmode_q;
    abort_d = abort_q;
    phase_d = phase_q;
    stage_d = stage_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    hold_d  = hold_q;
    ph      = phase_q;
    stg     = stage_q;
    t       = step_q;

    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;

    // Begin from idle: latch target and jump into START
    if (begin_req) begin
      addr_d  = item_i.dev_addr;
      reg_d   = item_i.reg_addr;
      left_d  = item_i.byte_count;
      rmode_d = (item_i.req_type == i2cm_pkg::REQ_READ);
      abort_d = 1'b0;
      ph      = i2cm_pkg::PH_START;
      stg     = i2cm_pkg::ST_ADDR_W;
      t       = 3'd0;
      phase_d = ph;
      stage_d = stg;
    end

    res.busy_res = (ph != i2cm_pkg::PH_IDLE);
    step_d       = t + 3'd1;

    unique case (ph)
      i2cm_pkg::PH_START: begin
        res.scl_level = (t < 3'd2);
        res.sda_level = (t == 3'd0);
        hold_d        = (t == 3'd0);
        if (t >= 3'd2) begin
          phase_d = i2cm_pkg::PH_SEND;
          step_d  = 3'd0;
          bit_d   = 3'd0;
          if (stg == i2cm_pkg::ST_DATA) begin
            stage_d = i2cm_pkg::ST_DATA;
            shift_d = {addr_q, 1'b1};
          end else begin
            stage_d = i2cm_pkg::ST_ADDR_W;
            shift_d = {addr_q, 1'b0};
          end
        end
      end
      i2cm_pkg::PH_SEND: begin
        if (t == 3'd0) begin
          res.scl_level = 1'b0;
          res.sda_level = hold_q;
        end else begin
          res.scl_level = (t >= 3'd2);
          res.sda_level = send_bit;
          hold_d        = send_bit;
        end
        if (t >= 3'd2) begin
          step_d = 3'd0;
          if (bit_q == 3'd7) begin
            phase_d = i2cm_pkg::PH_SEND_TAIL;
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
      end
      i2cm_pkg::PH_SEND_TAIL: begin
        res.scl_level = 1'b0;
        res.sda_level = hold_q;
        phase_d       = i2cm_pkg::PH_WACK;
        step_d        = 3'd0;
      end
      i2cm_pkg::PH_WACK: begin
        if (t == 3'd0) begin
          res.scl_level = 1'b0;
          res.sda_level = hold_q;
        end else begin
          res.scl_level = (t >= 3'd2) && (t <= 3'd5);
          res.sda_level = 1'b1;
          hold_d        = 1'b1;
        end
        if (t == 3'd4) begin
          abort_d = item_i.sda_in;
        end
        // End of ACK slot: decide the next byte
        if (t >= 3'd6) begin
          step_d = 3'd0;
          priority if (abort_q) begin
            phase_d = i2cm_pkg::PH_STOP;
          end else if (stg == i2cm_pkg::ST_ADDR_W) begin
            stage_d = i2cm_pkg::ST_REG;
            phase_d = i2cm_pkg::PH_SEND;
            bit_d   = 3'd0;
            shift_d = reg_q;
          end else if (stg == i2cm_pkg::ST_REG && rmode_q) begin
            stage_d = i2cm_pkg::ST_DATA;
            phase_d = i2cm_pkg::PH_START;
          end else if (stg == i2cm_pkg::ST_DATA && rmode_q) begin
            stage_d = i2cm_pkg::ST_READ;
            phase_d = sack_lvl ? i2cm_pkg::PH_STOP : i2cm_pkg::PH_RECV_PRE;
          end else if (left_q == 8'd0) begin
            stage_d = i2cm_pkg::ST_DATA;
            phase_d = i2cm_pkg::PH_STOP;
          end else begin
            left_d       = left_q - 8'd1;
            res.tx_taken = 1'b1;
            stage_d      = i2cm_pkg::ST_DATA;
            phase_d      = i2cm_pkg::PH_SEND;
            bit_d        = 3'd0;
            shift_d      = item_i.tx_byte;
          end
        end
      end
      i2cm_pkg::PH_RECV_PRE: begin
        res.scl_level = 1'b0;
        hold_d        = 1'b1;
        if (t >= 3'd1) begin
          phase_d = i2cm_pkg::PH_RECV_BIT;
          step_d  = 3'd0;
          bit_d   = 3'd0;
          shift_d = 8'd0;
        end
      end
      i2cm_pkg::PH_RECV_BIT: begin
        res.scl_level = (t >= 3'd1);
        if (t >= 3'd1) begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          step_d  = 3'd0;
          if (bit_q == 3'd7) begin
            phase_d = i2cm_pkg::PH_RECV_POST;
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
      end
      i2cm_pkg::PH_RECV_POST: begin
        res.scl_level = 1'b0;
        if (t >= 3'd1) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = shift_q;
          left_d       = left_q - 8'd1;
          phase_d      = i2cm_pkg::PH_SACK;
          step_d       = 3'd0;
        end
      end
      i2cm_pkg::PH_SACK: begin
        // NACK the last byte, ACK the rest
        if (t == 3'd0) begin
          res.scl_level = 1'b0;
          res.sda_level = hold_q;
        end else begin
          res.scl_level = (t == 3'd2);
          res.sda_level = sack_lvl;
          hold_d        = sack_lvl;
        end
        if (t >= 3'd3) begin
          phase_d = sack_lvl ? i2cm_pkg::PH_STOP : i2cm_pkg::PH_RECV_PRE;
          step_d  = 3'd0;
        end
      end
      i2cm_pkg::PH_STOP: begin
        res.scl_level = (t >= 3'd1);
        res.sda_level = (t >= 3'd2);
        hold_d        = (t >= 3'd2);
        if (t >= 3'd2) begin
          res.done_res   = 1'b1;
          res.nack_error = abort_q;
          abort_d        = 1'b0;
          phase_d        = i2cm_pkg::PH_IDLE;
          stage_d        = i2cm_pkg::ST_ADDR_W;
          step_d         = 3'd0;
        end
      end
      default: begin
        // Idle: lines released, counters parked
        phase_d      = i2cm_pkg::PH_IDLE;
        stage_d      = i2cm_pkg::ST_ADDR_W;
        step_d       = 3'd0;
        hold_d       = 1'b1;
        res.busy_res = 1'b0;
      end
    endcase
  end

  assign res_o = res;

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cm_pkg::PH_IDLE;
      stage_q <= i2cm_pkg::ST_ADDR_W;
      step_q  <= 3'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      left_q  <= 8'd0;
      addr_q  <= 7'd0;
      reg_q   <= 8'd0;
      rmode_q <= 1'b0;
      hold_q  <= 1'b1;
      abort_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      addr_q  <= addr_d;
      reg_q   <= reg_d;
      rmode_q <= rmode_d;
      hold_q  <= hold_d;
      abort_q <= abort_d;
    end
  end

  // A flagged NACK only ever comes with the STOP completion
  a_nack_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.nack_error |-> res.done_res && (phase_q == i2cm_pkg::PH_STOP))
    else $error("nack_error outside STOP completion");

  // Completing STOP returns the sequencer to idle
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.done_res |=> (phase_q == i2cm_pkg::PH_IDLE) && !abort_q)
    else $error("sequencer not idle after STOP");

  // A taken write byte is loaded into the shifter and sending starts at bit 0
  a_tx_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.tx_taken |=> (phase_q == i2cm_pkg::PH_SEND) && (bit_q == 3'd0) &&
                               (shift_q == $past(item_i.tx_byte)))
    else $error("tx byte not loaded for sending");

  // Every received byte is followed by the master ACK/NACK slot
  a_rx_to_sack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.rx_valid |=> (phase_q == i2cm_pkg::PH_SACK) && (step_q == 3'd0))
    else $error("received byte not followed by ACK slot");

endmodule

// File: rtl/i2c_master_register_access.sv
// Top level of the I2C master register access block: input register, sequencer, result register.
// Depends on i2cm_pkg, i2cm_in_stage and i2cm_seq.
//
// Each input beat is one pin-level delay tick of an open-drain I2C master running register
// write and register read transactions; each accepted beat yields exactly one result beat with
// the SCL/SDA drive for that tick and the status flags. A beat passes through the input register
// and then through the combinational sequencer step into the result register; one beat is taken
// every cycle as long as the result side keeps pace. The sequencer state advances once per tick,
// in the step between those two registers. A begin request while a transaction runs counts as a
// plain tick; tx_byte is consumed only on the tick whose result reports tx_taken, and sda_in is
// sampled on the ticks the bus protocol defines.
module i2c_master_register_access (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2cm_pkg::item_t    in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2cm_pkg::result_t  out_item_o
);

  logic              held_valid;
  i2cm_pkg::item_t   held_item;
  logic              advance;
  i2cm_pkg::result_t step_res;
  logic              out_valid_q;
  i2cm_pkg::result_t out_item_q;

  // Move a beat into the result register whenever that register is free or being drained
  assign advance = held_valid & (~out_valid_q | ~out_stall_i);

  i2cm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (held_item),
    .res_o  (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: dv/i2cm_bus_checker.sv
// Bus checker for i2c_master_register_access: predicts each tick's pin drive and flags.
// Depends on i2cm_pkg; watches both channels of the block and reports mismatches.
module i2cm_bus_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  i2cm_pkg::item_t   in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  i2cm_pkg::result_t out_item_i,
  output int                fails_o,
  output int                pending_o
);

  // Sequencer copy
  i2cm_pkg::phase_e cur_phase;
  i2cm_pkg::stage_e cur_stage;
  logic [2:0] tick_cnt;
  logic [2:0] bit_pos;
  logic [7:0] shreg;
  logic [7:0] left_cnt;
  logic [6:0] dev_q;
  logic [7:0] reg_q;
  logic       is_read;
  logic       sda_q;
  logic       nacked;

  i2cm_pkg::result_t pins_due[$];

  function automatic void enter(i2cm_pkg::stage_e s, i2cm_pkg::phase_e p);
    cur_stage = s;
    cur_phase = p;
    tick_cnt  = '0;
  endfunction

  function automatic void load_byte(i2cm_pkg::stage_e s, logic [7:0] v);
    enter(s, i2cm_pkg::PH_SEND);
    bit_pos = '0;
    shreg   = v;
  endfunction

  function automatic void clear_bus();
    cur_phase = i2cm_pkg::PH_IDLE;
    cur_stage = i2cm_pkg::ST_ADDR_W;
    tick_cnt  = '0;
    bit_pos   = '0;
    shreg     = '0;
    left_cnt  = '0;
    dev_q     = '0;
    reg_q     = '0;
    is_read   = 1'b0;
    sda_q     = 1'b1;
    nacked    = 1'b0;
  endfunction

  // One delay tick: returns the pin drive and flags, advances the sequencer
  function automatic i2cm_pkg::result_t bus_tick(i2cm_pkg::item_t it);
    i2cm_pkg::result_t r;
    i2cm_pkg::phase_e  ph;
    i2cm_pkg::stage_e  sg;
    logic [2:0]        t;
    logic              b;
    logic              a;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    // begin is honored only when idle
    if (cur_phase == i2cm_pkg::PH_IDLE && (it.req_type == i2cm_pkg::REQ_WRITE ||
                                           it.req_type == i2cm_pkg::REQ_READ)) begin
      dev_q    = it.dev_addr;
      reg_q    = it.reg_addr;
      left_cnt = it.byte_count;
      is_read  = (it.req_type == i2cm_pkg::REQ_READ);
      nacked   = 1'b0;
      enter(i2cm_pkg::ST_ADDR_W, i2cm_pkg::PH_START);
    end
    ph = cur_phase;
    sg = cur_stage;
    t  = tick_cnt;
    r.busy_res = (ph != i2cm_pkg::PH_IDLE);
    tick_cnt = t + 3'd1;

    case (ph)
      i2cm_pkg::PH_START: begin
        r.scl_level = (t < 3'd2);
        r.sda_level = (t == 3'd0);
        sda_q = r.sda_level;
        if (t >= 3'd2) begin
          // second START of a read carries address+R
          if (sg == i2cm_pkg::ST_DATA) load_byte(i2cm_pkg::ST_DATA, {dev_q, 1'b1});
          else load_byte(i2cm_pkg::ST_ADDR_W, {dev_q, 1'b0});
        end
      end
      i2cm_pkg::PH_SEND: begin
        b = shreg[3'd7 - bit_pos];
        if (t == 3'd0) begin
          r.scl_level = 1'b0;
          r.sda_level = sda_q;
        end else begin
          r.scl_level = (t >= 3'd2);
          r.sda_level = b;
          sda_q = b;
        end
        if (t >= 3'd2) begin
          tick_cnt = '0;
          if (bit_pos >= 3'd7) enter(sg, i2cm_pkg::PH_SEND_TAIL);
          else bit_pos = bit_pos + 3'd1;
        end
      end
      i2cm_pkg::PH_SEND_TAIL: begin
        r.scl_level = 1'b0;
        r.sda_level = sda_q;
        enter(sg, i2cm_pkg::PH_WACK);
      end
      i2cm_pkg::PH_WACK: begin
        if (t == 3'd0) begin
          r.scl_level = 1'b0;
          r.sda_level = sda_q;
        end else begin
          r.scl_level = (t >= 3'd2 && t <= 3'd5);
          r.sda_level = 1'b1;
          sda_q = 1'b1;
        end
        if (t == 3'd4) nacked = it.sda_in;
        if (t >= 3'd6) begin
          if (nacked) enter(sg, i2cm_pkg::PH_STOP);
          else if (sg == i2cm_pkg::ST_ADDR_W) load_byte(i2cm_pkg::ST_REG, reg_q);
          else if (sg == i2cm_pkg::ST_REG && is_read)
            enter(i2cm_pkg::ST_DATA, i2cm_pkg::PH_START);
          else if (sg == i2cm_pkg::ST_DATA && is_read) begin
            if (left_cnt == 8'd0) enter(i2cm_pkg::ST_READ, i2cm_pkg::PH_STOP);
            else enter(i2cm_pkg::ST_READ, i2cm_pkg::PH_RECV_PRE);
          end else if (left_cnt == 8'd0) enter(i2cm_pkg::ST_DATA, i2cm_pkg::PH_STOP);
          else begin
            left_cnt = left_cnt - 8'd1;
            r.tx_taken = 1'b1;
            load_byte(i2cm_pkg::ST_DATA, it.tx_byte);
          end
        end
      end
      i2cm_pkg::PH_RECV_PRE: begin
        r.scl_level = 1'b0;
        sda_q = 1'b1;
        if (t >= 3'd1) begin
          enter(sg, i2cm_pkg::PH_RECV_BIT);
          bit_pos = '0;
          shreg   = '0;
        end
      end
      i2cm_pkg::PH_RECV_BIT: begin
        r.scl_level = (t >= 3'd1);
        if (t >= 3'd1) begin
          shreg = {shreg[6:0], it.sda_in};
          tick_cnt = '0;
          if (bit_pos >= 3'd7) enter(sg, i2cm_pkg::PH_RECV_POST);
          else bit_pos = bit_pos + 3'd1;
        end
      end
      i2cm_pkg::PH_RECV_POST: begin
        r.scl_level = 1'b0;
        if (t >= 3'd1) begin
          r.rx_valid = 1'b1;
          r.rx_byte  = shreg;
          left_cnt   = left_cnt - 8'd1;
          enter(sg, i2cm_pkg::PH_SACK);
        end
      end
      i2cm_pkg::PH_SACK: begin
        // master NACKs the last byte
        a = (left_cnt == 8'd0);
        if (t == 3'd0) begin
          r.scl_level = 1'b0;
          r.sda_level = sda_q;
        end else begin
          r.scl_level = (t == 3'd2);
          r.sda_level = a;
          sda_q = a;
        end
        if (t >= 3'd3) begin
          if (a) enter(sg, i2cm_pkg::PH_STOP);
          else enter(sg, i2cm_pkg::PH_RECV_PRE);
        end
      end
      i2cm_pkg::PH_STOP: begin
        r.scl_level = (t >= 3'd1);
        r.sda_level = (t >= 3'd2);
        sda_q = r.sda_level;
        if (t >= 3'd2) begin
          r.done_res   = 1'b1;
          r.nack_error = nacked;
          nacked = 1'b0;
          enter(i2cm_pkg::ST_ADDR_W, i2cm_pkg::PH_IDLE);
        end
      end
      default: begin
        enter(i2cm_pkg::ST_ADDR_W, i2cm_pkg::PH_IDLE);
        sda_q = 1'b1;
        r.busy_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails_o++;
    end
  endtask

  // Compare result beats against the oldest prediction, then predict the new tick
  always @(posedge clk_i or negedge rst_ni) begin
    i2cm_pkg::result_t want;
    if (!rst_ni) begin
      clear_bus();
      pins_due.delete();
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pins_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_item_i);
          fails_o++;
        end else begin
          want = pins_due.pop_front();
          check_field("scl_level",  8'(want.scl_level),  8'(out_item_i.scl_level));
          check_field("sda_level",  8'(want.sda_level),  8'(out_item_i.sda_level));
          check_field("tx_taken",   8'(want.tx_taken),   8'(out_item_i.tx_taken));
          check_field("rx_valid",   8'(want.rx_valid),   8'(out_item_i.rx_valid));
          check_field("rx_byte",    want.rx_byte,        out_item_i.rx_byte);
          check_field("done_res",   8'(want.done_res),   8'(out_item_i.done_res));
          check_field("nack_error", 8'(want.nack_error), 8'(out_item_i.nack_error));
          check_field("busy_res",   8'(want.busy_res),   8'(out_item_i.busy_res));
        end
      end
      if (in_valid_i && !in_stall_i) pins_due.push_back(bus_tick(in_item_i));
      pending_o <= pins_due.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the i2c_master_register_access testbench: clock, reset, tick stimulus and verdict.
// Depends on i2cm_pkg, the block's RTL and i2cm_bus_checker.
module testbench;

  // Unused request code, behaves as a plain tick
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  i2cm_pkg::item_t   in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  i2cm_pkg::result_t out_item_o;

  int fails;
  int pending;
  int sent;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_req_cnt;

  i2c_master_register_access u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  i2cm_bus_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("i2c_master_register_access verification failed");
    $finish;
  end

  // Result side: random stall, one long hold-off on request
  initial begin
    int holds_done;
    holds_done  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req_cnt != holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (80) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Offer one tick beat and wait until it is taken
  task automatic push_tick(i2cm_pkg::item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic i2cm_pkg::item_t make_tick(logic [1:0] req, logic [6:0] dev,
                                                logic [7:0] rg, logic [7:0] cnt,
                                                logic [7:0] txb, logic sda);
    i2cm_pkg::item_t it;
    it.req_type   = req;
    it.dev_addr   = dev;
    it.reg_addr   = rg;
    it.byte_count = cnt;
    it.tx_byte    = txb;
    it.sda_in     = sda;
    return it;
  endfunction

  // Random tick; begins mostly ask for short transfers, long writes only when NACKs are likely
  function automatic i2cm_pkg::item_t rand_tick(int nack_pct, int begin_pct);
    i2cm_pkg::item_t it;
    int              pick;
    it = make_tick(i2cm_pkg::REQ_TICK, 7'($urandom_range(127)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   ($urandom_range(99) < nack_pct));
    pick = $urandom_range(99);
    if (pick < begin_pct) begin
      it.req_type = $urandom_range(1) ? i2cm_pkg::REQ_WRITE : i2cm_pkg::REQ_READ;
      if (!(it.req_type == i2cm_pkg::REQ_WRITE && nack_pct >= 50 && $urandom_range(3) == 0))
        it.byte_count = 8'($urandom_range(3));
    end else if (pick < begin_pct + 3) begin
      it.req_type = REQ_SPARE;
    end
    return it;
  endfunction

  initial begin
    int nack_pct;
    int begin_pct;
    int seg_len;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    rst_ni        = 1'b0;
    sent          = 0;
    send_gap_pct  = 10;
    recv_gap_pct  = 60;
    hold_req_cnt  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle ticks, spare code, zero-length write, begins while busy
    push_tick(make_tick(i2cm_pkg::REQ_TICK,  7'h7f, 8'hff, 8'hff, 8'hff, 1'b1));
    push_tick(make_tick(REQ_SPARE,           7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    push_tick(make_tick(i2cm_pkg::REQ_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    push_tick(make_tick(i2cm_pkg::REQ_WRITE, 7'h7f, 8'hff, 8'h00, 8'hff, 1'b0));
    push_tick(make_tick(i2cm_pkg::REQ_READ,  7'h00, 8'h00, 8'hff, 8'h00, 1'b1));
    push_tick(make_tick(REQ_SPARE,           7'h7f, 8'hff, 8'hff, 8'hff, 1'b1));
    push_tick(make_tick(i2cm_pkg::REQ_WRITE, 7'h00, 8'h00, 8'h01, 8'h00, 1'b0));
    repeat (6) push_tick(make_tick(i2cm_pkg::REQ_TICK, 7'h2a, 8'h55, 8'haa, 8'h5a, 1'b0));

    // Random segments, each with its own NACK and begin density
    while (sent < 1650) begin
      case ($urandom_range(4))
        0, 1, 2: nack_pct = 2;
        3:       nack_pct = 12;
        default: nack_pct = 50;
      endcase
      case ($urandom_range(2))
        0:       begin_pct = 5;
        1:       begin_pct = 10;
        default: begin_pct = 25;
      endcase
      seg_len = $urandom_range(250, 40);
      repeat (seg_len) begin
        if (sent >= 1650) break;
        if (sent >= 1100) begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end else if (sent >= 550) begin
          send_gap_pct = 60;
          recv_gap_pct = 10;
        end
        if (sent == 200) hold_req_cnt++;
        if (sent == 800) begin
          // let every outstanding beat drain before going on
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          wait (pending == 0);
        end
        push_tick(rand_tick(nack_pct, begin_pct));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("i2c_master_register_access verification clean");
    end else begin
      $display("i2c_master_register_access verification failed");
    end
    $finish;
  end

endmodule
